// ===== rtl/core/lsdm_pkg.sv =====
// Shared types, constants and coefficient tables of the line sensor distortion map.
`default_nettype none
package lsdm_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_FWD  = 2'd1,
    REQ_INV  = 2'd2,
    REQ_RSVD = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_LEFT    = 2'd2,
    STAT_NOCONV  = 2'd3
  } status_e;

  // Weight of a Legendre y factor evaluated at zero, in eighths.
  typedef enum logic [1:0] {
    PY_P8,
    PY_M4,
    PY_P3
  } py_e;

  typedef enum logic [1:0] {
    MU_IDLE,
    MU_PROD,
    MU_RND,
    MU_SAT
  } mul_state_e;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_UXS,
    SQ_TS,
    SQ_POW,
    SQ_PL,
    SQ_LT,
    SQ_LACC,
    SQ_S,
    SQ_RH,
    SQ_RF,
    SQ_RP,
    SQ_FX,
    SQ_OUT
  } seq_state_e;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [4:0]         sh;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } mul_rsp_t;

  localparam int unsigned COEFF_DEPTH = 32;
  localparam int unsigned COEFF_AW    = 5;
  localparam int unsigned LEG_ACTIVE  = 11;
  localparam int unsigned RES_DEGREE  = 5;

  localparam logic [4:0] COL_BASE = 5'd20;
  localparam logic [4:0] ROW_BASE = 5'd25;

  localparam logic [4:0] SH_NONE = 5'd0;
  localparam logic [4:0] SH_HALF = 5'd1;
  localparam logic [4:0] SH_EIGHTH = 5'd3;
  localparam logic [4:0] SH_Q20 = 5'd20;
  localparam logic [4:0] SH_Q24 = 5'd24;
  localparam logic [4:0] SH_Q30 = 5'd30;

  localparam logic signed [63:0] ONE_Q30   = 64'sh0000_0000_4000_0000;
  localparam logic signed [63:0] TWO_P32   = 64'sh0000_0001_0000_0000;
  localparam logic [63:0]        MAG_LIM   = 64'h1000_0000_0000_0000;
  localparam logic signed [63:0] RECIP_PITCH = 64'sd1290555077;
  localparam logic signed [63:0] S_CENTER  = 64'sd2621964288;
  localparam logic signed [63:0] I32_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN   = -64'sd2147483648;

  localparam logic [30:0] HW_RESET   = 31'd34078720;
  localparam logic [30:0] IHW_RESET  = 31'd33038210;
  localparam logic [19:0] PP_RESET   = 20'd13631;

  localparam logic [1:0] CFG_HW  = 2'd0;
  localparam logic [1:0] CFG_IHW = 2'd1;
  localparam logic [1:0] CFG_PP  = 2'd2;

  // Only the terms whose y factor is nonzero at y = 0 are visited.
  function automatic logic [4:0] leg_slot(input logic [3:0] idx);
    logic [4:0] r;
    case (idx)
      4'd0:    r = 5'd1;
      4'd1:    r = 5'd2;
      4'd2:    r = 5'd4;
      4'd3:    r = 5'd6;
      4'd4:    r = 5'd8;
      4'd5:    r = 5'd9;
      4'd6:    r = 5'd11;
      4'd7:    r = 5'd13;
      4'd8:    r = 5'd15;
      4'd9:    r = 5'd17;
      4'd10:   r = 5'd19;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] leg_xdeg(input logic [3:0] idx);
    logic [2:0] r;
    case (idx)
      4'd0:    r = 3'd1;
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd2;
      4'd3:    r = 3'd1;
      4'd4:    r = 3'd3;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd2;
      4'd7:    r = 3'd4;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd3;
      4'd10:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic py_e leg_py(input logic [3:0] idx);
    py_e r;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd7, 4'd10: r = PY_P8;
      4'd1, 4'd3, 4'd6, 4'd9:        r = PY_M4;
      default:                       r = PY_P3;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lsdm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lsdm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/lsdm_mul.sv =====
// Shared multiplier: 32x32 partial products, then rounding shift and magnitude saturation.
`default_nettype none
module lsdm_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lsdm_pkg::mul_req_t req_i,
  output lsdm_pkg::mul_rsp_t     rsp_o
);

  lsdm_pkg::mul_state_e state_q, state_d;

  logic [63:0]        ma_q, mb_q;
  logic               neg_q;
  logic [4:0]         sh_q;
  logic [1:0]         step_q;
  logic [127:0]       acc_q;
  logic               hinz_q;
  logic [63:0]        lo_q;
  logic signed [63:0] res_q;
  logic               done_q;

  logic [63:0]  ma_in, mb_in;
  logic [31:0]  chunk_a, chunk_b;
  logic [63:0]  pp;
  logic [1:0]   pos;
  logic [127:0] pp_sh;
  logic [127:0] round_add, rounded, quot;
  logic [63:0]  mag;
  logic         a_hi, b_hi;
  logic [1:0]   nxt_step;
  logic         nxt_ok;

  assign ma_in = req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a);
  assign mb_in = req_i.b[63] ? 64'(-req_i.b) : 64'(req_i.b);

  assign chunk_a = step_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign chunk_b = step_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp      = chunk_a * chunk_b;
  assign pos     = {1'b0, step_q[1]} + {1'b0, step_q[0]};
  assign pp_sh   = {64'd0, pp} << {pos, 5'd0};

  assign round_add = (sh_q == 5'd0) ? 128'd0 : (128'd1 << (sh_q - 5'd1));
  assign rounded   = acc_q + round_add;
  assign quot      = rounded >> sh_q;
  assign mag       = (hinz_q || (lo_q > lsdm_pkg::MAG_LIM)) ? lsdm_pkg::MAG_LIM : lo_q;

  assign a_hi = |ma_q[63:32];
  assign b_hi = |mb_q[63:32];

  // Partial products with a zero upper half are skipped.
  always_comb begin
    nxt_step = step_q;
    nxt_ok   = 1'b0;
    for (int k = 3; k >= 1; k--) begin
      if ((2'(k) > step_q) && (!k[1] || a_hi) && (!k[0] || b_hi)) begin
        nxt_step = 2'(k);
        nxt_ok   = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lsdm_pkg::MU_IDLE: begin
        if (req_i.start) begin
          state_d = lsdm_pkg::MU_PROD;
        end
      end
      lsdm_pkg::MU_PROD: begin
        if (!nxt_ok) begin
          state_d = lsdm_pkg::MU_RND;
        end
      end
      lsdm_pkg::MU_RND: state_d = lsdm_pkg::MU_SAT;
      lsdm_pkg::MU_SAT: state_d = lsdm_pkg::MU_IDLE;
      default:          state_d = lsdm_pkg::MU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsdm_pkg::MU_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == lsdm_pkg::MU_SAT);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lsdm_pkg::MU_IDLE: begin
        ma_q   <= ma_in;
        mb_q   <= mb_in;
        neg_q  <= req_i.a[63] ^ req_i.b[63];
        sh_q   <= req_i.sh;
        step_q <= 2'd0;
        acc_q  <= 128'd0;
      end
      lsdm_pkg::MU_PROD: begin
        acc_q  <= acc_q + pp_sh;
        step_q <= nxt_step;
      end
      lsdm_pkg::MU_RND: begin
        hinz_q <= |quot[127:64];
        lo_q   <= quot[63:0];
      end
      lsdm_pkg::MU_SAT: begin
        res_q <= neg_q ? -$signed(mag) : $signed(mag);
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/line_sensor_distortion_map_top.sv =====
// Line sensor distortion map: Legendre and residual polynomial correction, forward and inverse.
//
// Input channel (in_valid_i / in_stall_o) takes one request: a coefficient load,
// a forward map or an inverse map. Every request gives exactly one result on the
// output channel (out_valid_o / out_stall_i) with x_out_o, y_out_o and status_o.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes half width,
// reciprocal half width and pixel pitch; it is always ready.
// All arithmetic runs on one shared multiplier with rounding and saturation. A load,
// a reserved request or an outside point goes from idle straight to the output
// state and gives its result there as soon as the output register is free.
// A forward map takes 37 multiplies. An inverse map takes one multiply, then 37
// multiplies per iteration, up to MAX_ITERATIONS iterations.
// The block takes a new request only when it is idle; the result sits in an output
// register, so the next request can start while the receiver holds a result.
// When the receiver stalls, the result holds and a finished next result waits.
// Reset empties the output register, returns to idle and restores the register
// defaults; the coefficient store is not cleared and must be loaded before use.
`default_nettype none
module line_sensor_distortion_map_top #(
  parameter int unsigned MAX_ITERATIONS = 50
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [4:0]  coeff_index_i,
  input  wire logic signed [31:0] coeff_value_i,
  input  wire logic signed [31:0] x_in_i,
  input  wire logic signed [31:0] y_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic [1:0]       status_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned ITER_W = $clog2(MAX_ITERATIONS + 1);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > lsdm_pkg::I32_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < lsdm_pkg::I32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  lsdm_pkg::seq_state_e state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              inv_q, inv_d;
  logic              row_q, row_d;
  logic              have_prev_q, have_prev_d;
  logic              out_valid_q, out_valid_d;
  logic [30:0]       hw_q, ihw_q;
  logic [19:0]       pp_q;

  logic signed [31:0] x_q, x_d, y_q, y_d, xt_q, xt_d, yt_q, yt_d;
  logic signed [31:0] rx_q, rx_d, ry_q, ry_d;
  lsdm_pkg::status_e  rs_q, rs_d;
  logic signed [31:0] xo_q, xo_d, yo_q, yo_d;
  lsdm_pkg::status_e  so_q, so_d;
  logic signed [63:0] uxs_q, uxs_d, t_q, t_d, acc_q, acc_d, dl_q, dl_d, u_q, u_d;
  logic signed [63:0] s_q, s_d, r_q, r_d, dcol_q, dcol_d, drow_q, drow_d;
  logic signed [63:0] tk_q [4];
  logic signed [63:0] tk_d [4];
  logic signed [63:0] pl_q [4];
  logic signed [63:0] pl_d [4];

  lsdm_pkg::mul_req_t mreq;
  lsdm_pkg::mul_rsp_t mrsp;

  logic                 ram_we;
  logic [lsdm_pkg::COEFF_AW-1:0] ram_raddr;
  logic [31:0]          ram_rdata;
  logic signed [63:0]   coeff;

  logic               accept;
  logic               out_free;
  logic signed [63:0] res;
  logic               consume;
  logic [32:0]        xmag;
  logic signed [32:0] xs33;
  logic signed [63:0] psel;
  logic [2:0]         xdeg;
  logic signed [63:0] sum_tu;
  logic signed [31:0] xn, yn;
  logic signed [32:0] dx, dy;
  logic               conv;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != lsdm_pkg::SQ_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign ram_we      = accept && (req_type_i == lsdm_pkg::REQ_LOAD);
  assign coeff       = 64'($signed(ram_rdata));
  assign res         = mrsp.res;
  assign consume     = (phase_q == 2'd2) && mrsp.done;
  assign xs33        = {x_in_i[31], x_in_i};
  assign xmag        = x_in_i[31] ? 33'(-xs33) : 33'(xs33);
  assign xdeg        = lsdm_pkg::leg_xdeg(cnt_q);

  lsdm_ram #(
    .WIDTH(32),
    .DEPTH(lsdm_pkg::COEFF_DEPTH)
  ) u_coeff_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (coeff_index_i),
    .wdata_i (coeff_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lsdm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  // Legendre value of the degree that the current term needs.
  always_comb begin
    case (xdeg)
      3'd0:    psel = lsdm_pkg::ONE_Q30;
      3'd1:    psel = t_q;
      default: psel = pl_q[2'(xdeg - 3'd2)];
    endcase
  end

  // Operand and coefficient address selection for the shared multiplier.
  always_comb begin
    mreq.start = (phase_q == 2'd1);
    mreq.a     = 64'sd0;
    mreq.b     = 64'sd0;
    mreq.sh    = lsdm_pkg::SH_NONE;
    ram_raddr  = '0;
    case (state_q)
      lsdm_pkg::SQ_UXS: begin
        mreq.a  = -64'(x_q);
        mreq.b  = 64'($unsigned(ihw_q));
        mreq.sh = lsdm_pkg::SH_Q20;
      end
      lsdm_pkg::SQ_TS: begin
        mreq.a  = -64'(xt_q);
        mreq.b  = 64'($unsigned(ihw_q));
        mreq.sh = lsdm_pkg::SH_Q20;
      end
      lsdm_pkg::SQ_POW: begin
        mreq.a  = (cnt_q == 4'd0) ? t_q : tk_q[2'(cnt_q[1:0] - 2'd1)];
        mreq.b  = t_q;
        mreq.sh = lsdm_pkg::SH_Q30;
      end
      lsdm_pkg::SQ_PL: begin
        mreq.b = 64'sd1;
        case (cnt_q[1:0])
          2'd0: begin
            mreq.a  = 64'sd3 * tk_q[0] - lsdm_pkg::ONE_Q30;
            mreq.sh = lsdm_pkg::SH_HALF;
          end
          2'd1: begin
            mreq.a  = 64'sd5 * tk_q[1] - 64'sd3 * t_q;
            mreq.sh = lsdm_pkg::SH_HALF;
          end
          2'd2: begin
            mreq.a  = 64'sd35 * tk_q[2] - 64'sd30 * tk_q[0] + 64'sd3 * lsdm_pkg::ONE_Q30;
            mreq.sh = lsdm_pkg::SH_EIGHTH;
          end
          default: begin
            mreq.a  = 64'sd63 * tk_q[3] - 64'sd70 * tk_q[1] + 64'sd15 * t_q;
            mreq.sh = lsdm_pkg::SH_EIGHTH;
          end
        endcase
      end
      lsdm_pkg::SQ_LT: begin
        ram_raddr = lsdm_pkg::leg_slot(cnt_q);
        mreq.a    = coeff;
        mreq.b    = psel;
        mreq.sh   = lsdm_pkg::SH_Q24;
      end
      lsdm_pkg::SQ_LACC: begin
        mreq.a  = acc_q;
        mreq.b  = 64'sd1;
        mreq.sh = lsdm_pkg::SH_EIGHTH;
      end
      lsdm_pkg::SQ_S: begin
        mreq.a  = 64'(xt_q);
        mreq.b  = lsdm_pkg::RECIP_PITCH;
        mreq.sh = lsdm_pkg::SH_Q24;
      end
      lsdm_pkg::SQ_RH: begin
        ram_raddr = (row_q ? lsdm_pkg::ROW_BASE : lsdm_pkg::COL_BASE) + 5'(cnt_q);
        mreq.a    = r_q;
        mreq.b    = s_q;
        mreq.sh   = lsdm_pkg::SH_Q20;
      end
      lsdm_pkg::SQ_RF: begin
        mreq.a  = r_q;
        mreq.b  = s_q;
        mreq.sh = lsdm_pkg::SH_Q20;
      end
      lsdm_pkg::SQ_RP: begin
        mreq.a  = r_q;
        mreq.b  = 64'($unsigned(pp_q));
        mreq.sh = lsdm_pkg::SH_Q24;
      end
      lsdm_pkg::SQ_FX: begin
        mreq.a  = inv_q ? (uxs_q - dl_q) : u_q;
        mreq.b  = 64'($unsigned(hw_q));
        mreq.sh = lsdm_pkg::SH_Q30;
      end
      default: begin
        mreq.start = 1'b0;
      end
    endcase
  end

  assign sum_tu = t_q + dl_q;
  assign xn = inv_q ? sat32(-res - dcol_q) : sat32(-res + dcol_q);
  assign yn = inv_q ? sat32(64'(y_q) - drow_q) : sat32(64'(y_q) + drow_q);
  assign dx = {xn[31], xn} - {xt_q[31], xt_q};
  assign dy = {yn[31], yn} - {yt_q[31], yt_q};
  assign conv = have_prev_q &&
                ((dx == 33'sd0) || (dx == 33'sd1) || (dx == -33'sd1)) &&
                ((dy == 33'sd0) || (dy == 33'sd1) || (dy == -33'sd1));

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    iter_d      = iter_q;
    inv_d       = inv_q;
    row_d       = row_q;
    have_prev_d = have_prev_q;
    out_valid_d = out_valid_q;
    x_d = x_q;   y_d = y_q;   xt_d = xt_q; yt_d = yt_q;
    rx_d = rx_q; ry_d = ry_q; rs_d = rs_q;
    xo_d = xo_q; yo_d = yo_q; so_d = so_q;
    uxs_d = uxs_q; t_d = t_q; acc_d = acc_q; dl_d = dl_q; u_d = u_q;
    s_d = s_q; r_d = r_q; dcol_d = dcol_q; drow_d = drow_q;
    tk_d = tk_q;
    pl_d = pl_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (phase_q != 2'd2) begin
      phase_d = phase_q + 2'd1;
    end

    case (state_q)
      lsdm_pkg::SQ_IDLE: begin
        phase_d = 2'd0;
        if (accept) begin
          x_d  = x_in_i;
          y_d  = y_in_i;
          xt_d = x_in_i;
          yt_d = y_in_i;
          rx_d = 32'sd0;
          ry_d = 32'sd0;
          rs_d = lsdm_pkg::STAT_OK;
          have_prev_d = 1'b0;
          iter_d = '0;
          case (lsdm_pkg::req_e'(req_type_i))
            lsdm_pkg::REQ_FWD: begin
              inv_d = 1'b0;
              if (xmag > {2'b00, hw_q}) begin
                rx_d    = x_in_i;
                ry_d    = y_in_i;
                rs_d    = lsdm_pkg::STAT_OUTSIDE;
                state_d = lsdm_pkg::SQ_OUT;
              end else begin
                state_d = lsdm_pkg::SQ_TS;
              end
            end
            lsdm_pkg::REQ_INV: begin
              inv_d   = 1'b1;
              state_d = lsdm_pkg::SQ_UXS;
            end
            default: begin
              state_d = lsdm_pkg::SQ_OUT;
            end
          endcase
        end
      end
      lsdm_pkg::SQ_UXS: begin
        if (consume) begin
          uxs_d   = res;
          phase_d = 2'd0;
          state_d = lsdm_pkg::SQ_TS;
        end
      end
      lsdm_pkg::SQ_TS: begin
        if (consume) begin
          phase_d = 2'd0;
          cnt_d   = 4'd0;
          state_d = lsdm_pkg::SQ_POW;
          if (!inv_q) begin
            if (res > lsdm_pkg::ONE_Q30) begin
              t_d = lsdm_pkg::ONE_Q30;
            end else if (res < -lsdm_pkg::ONE_Q30) begin
              t_d = -lsdm_pkg::ONE_Q30;
            end else begin
              t_d = res;
            end
          end else if ((res > lsdm_pkg::ONE_Q30) || (res < -lsdm_pkg::ONE_Q30)) begin
            rx_d    = x_q;
            ry_d    = y_q;
            rs_d    = lsdm_pkg::STAT_LEFT;
            state_d = lsdm_pkg::SQ_OUT;
          end else begin
            t_d = res;
          end
        end
      end
      lsdm_pkg::SQ_POW: begin
        if (consume) begin
          tk_d[cnt_q[1:0]] = res;
          phase_d = 2'd0;
          cnt_d   = cnt_q + 4'd1;
          if (cnt_q == 4'd3) begin
            cnt_d   = 4'd0;
            state_d = lsdm_pkg::SQ_PL;
          end
        end
      end
      lsdm_pkg::SQ_PL: begin
        if (consume) begin
          pl_d[cnt_q[1:0]] = res;
          phase_d = 2'd0;
          cnt_d   = cnt_q + 4'd1;
          if (cnt_q == 4'd3) begin
            cnt_d   = 4'd0;
            acc_d   = 64'sd0;
            state_d = lsdm_pkg::SQ_LT;
          end
        end
      end
      lsdm_pkg::SQ_LT: begin
        if (consume) begin
          case (lsdm_pkg::leg_py(cnt_q))
            lsdm_pkg::PY_P8: acc_d = acc_q + (res <<< 3);
            lsdm_pkg::PY_M4: acc_d = acc_q - (res <<< 2);
            default:         acc_d = acc_q + res + (res <<< 1);
          endcase
          phase_d = 2'd0;
          cnt_d   = cnt_q + 4'd1;
          if (cnt_q == 4'(lsdm_pkg::LEG_ACTIVE - 1)) begin
            state_d = lsdm_pkg::SQ_LACC;
          end
        end
      end
      lsdm_pkg::SQ_LACC: begin
        if (consume) begin
          dl_d    = res;
          phase_d = 2'd0;
          state_d = lsdm_pkg::SQ_S;
        end
      end
      lsdm_pkg::SQ_S: begin
        if (consume) begin
          // The sum t + dL is formed here, after the correction has settled.
          if (sum_tu > lsdm_pkg::TWO_P32) begin
            u_d = lsdm_pkg::TWO_P32;
          end else if (sum_tu < -lsdm_pkg::TWO_P32) begin
            u_d = -lsdm_pkg::TWO_P32;
          end else begin
            u_d = sum_tu;
          end
          s_d     = lsdm_pkg::S_CENTER - res;
          r_d     = 64'sd0;
          row_d   = 1'b0;
          cnt_d   = 4'(lsdm_pkg::RES_DEGREE - 1);
          phase_d = 2'd0;
          state_d = lsdm_pkg::SQ_RH;
        end
      end
      lsdm_pkg::SQ_RH: begin
        if (consume) begin
          r_d     = res + coeff;
          phase_d = 2'd0;
          cnt_d   = cnt_q - 4'd1;
          if (cnt_q == 4'd0) begin
            state_d = lsdm_pkg::SQ_RF;
          end
        end
      end
      lsdm_pkg::SQ_RF: begin
        if (consume) begin
          r_d     = res;
          phase_d = 2'd0;
          state_d = lsdm_pkg::SQ_RP;
        end
      end
      lsdm_pkg::SQ_RP: begin
        if (consume) begin
          phase_d = 2'd0;
          if (!row_q) begin
            dcol_d  = -res;
            row_d   = 1'b1;
            r_d     = 64'sd0;
            cnt_d   = 4'(lsdm_pkg::RES_DEGREE - 1);
            state_d = lsdm_pkg::SQ_RH;
          end else begin
            drow_d  = res;
            state_d = lsdm_pkg::SQ_FX;
          end
        end
      end
      lsdm_pkg::SQ_FX: begin
        if (consume) begin
          phase_d = 2'd0;
          if (!inv_q) begin
            rx_d    = xn;
            ry_d    = yn;
            rs_d    = lsdm_pkg::STAT_OK;
            state_d = lsdm_pkg::SQ_OUT;
          end else begin
            xt_d        = xn;
            yt_d        = yn;
            have_prev_d = 1'b1;
            iter_d      = iter_q + 1'b1;
            if (conv) begin
              rx_d    = xn;
              ry_d    = yn;
              rs_d    = lsdm_pkg::STAT_OK;
              state_d = lsdm_pkg::SQ_OUT;
            end else if (ITER_W'(iter_q + 1'b1) == ITER_W'(MAX_ITERATIONS)) begin
              rx_d    = x_q;
              ry_d    = y_q;
              rs_d    = lsdm_pkg::STAT_NOCONV;
              state_d = lsdm_pkg::SQ_OUT;
            end else begin
              state_d = lsdm_pkg::SQ_TS;
            end
          end
        end
      end
      lsdm_pkg::SQ_OUT: begin
        phase_d = 2'd0;
        if (out_free) begin
          xo_d        = rx_q;
          yo_d        = ry_q;
          so_d        = rs_q;
          out_valid_d = 1'b1;
          state_d     = lsdm_pkg::SQ_IDLE;
        end
      end
      default: begin
        state_d = lsdm_pkg::SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsdm_pkg::SQ_IDLE;
      phase_q     <= 2'd0;
      cnt_q       <= 4'd0;
      iter_q      <= '0;
      inv_q       <= 1'b0;
      row_q       <= 1'b0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
      hw_q        <= lsdm_pkg::HW_RESET;
      ihw_q       <= lsdm_pkg::IHW_RESET;
      pp_q        <= lsdm_pkg::PP_RESET;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      iter_q      <= iter_d;
      inv_q       <= inv_d;
      row_q       <= row_d;
      have_prev_q <= have_prev_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          lsdm_pkg::CFG_HW:  hw_q  <= cfg_data_i[30:0];
          lsdm_pkg::CFG_IHW: ihw_q <= cfg_data_i[30:0];
          lsdm_pkg::CFG_PP:  pp_q  <= cfg_data_i[19:0];
          default: begin
            pp_q <= pp_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;   y_q <= y_d;   xt_q <= xt_d; yt_q <= yt_d;
    rx_q <= rx_d; ry_q <= ry_d; rs_q <= rs_d;
    xo_q <= xo_d; yo_q <= yo_d; so_q <= so_d;
    uxs_q <= uxs_d; t_q <= t_d; acc_q <= acc_d; dl_q <= dl_d; u_q <= u_d;
    s_q <= s_d; r_q <= r_d; dcol_q <= dcol_d; drow_q <= drow_d;
    tk_q <= tk_d;
    pl_q <= pl_d;
  end

  assign out_valid_o = out_valid_q;
  assign x_out_o     = xo_q;
  assign y_out_o     = yo_q;
  assign status_o    = so_q;

endmodule
`default_nettype wire

// ===== rtl/core/lsdm_checker.sv =====
// Port-level checker for the line sensor distortion map, bound to the top level.
`default_nettype none
module lsdm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] x_out_o,
  input wire logic [31:0] y_out_o,
  input wire logic [1:0]  status_o
);

  // A stalled result stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(x_out_o) &&
    $stable(y_out_o) && $stable(status_o))
    else $error("stalled result changed or dropped");

  // Every accepted request keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after an accepted request");

  // A new result is published exactly as the sequencer returns to idle.
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result published while the block is still busy");

endmodule

bind line_sensor_distortion_map_top lsdm_checker u_lsdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .x_out_o     (x_out_o),
  .y_out_o     (y_out_o),
  .status_o    (status_o)
);
`default_nettype wire
